@@ rtl/lemt_pkg.sv @@
`default_nettype none
package lemt_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int WINDOW_LEN  = 5;
  localparam int TS_BITS     = 32;
  localparam int THR_BITS    = 10;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 1;

  localparam int POS_BITS = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam logic [POS_BITS-1:0] LAST_POS = POS_BITS'(WINDOW_LEN - 1);

  // Window sum and the reciprocal used to divide it by the window length.
  localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int DIV_SH     = SUM_BITS + $clog2(WINDOW_LEN) + 1;
  localparam int RECIP_BITS = DIV_SH + 1;
  localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
  localparam logic [RECIP_BITS-1:0] RECIP =
    RECIP_BITS'(((64'd1 << DIV_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPAN_THRESHOLD = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_ONSET_OFFSET   = CFG_IDX_BITS'(1);

  localparam logic [THR_BITS-1:0] THR_RESET    = THR_BITS'(7);
  localparam logic [TS_BITS-1:0]  OFFSET_RESET = TS_BITS'(4000);

endpackage
`default_nettype wire

@@ rtl/lemt_if.sv @@
`default_nettype none
interface lemt_in_if;
  import lemt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic [TS_BITS-1:0]     timestamp_us;
  modport source (output valid, output sample, output timestamp_us, input ready);
  modport sink   (input valid, input sample, input timestamp_us, output ready);
endinterface

interface lemt_out_if;
  import lemt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] top_level;
  logic [SAMPLE_BITS-1:0] bottom_level;
  logic [SAMPLE_BITS-1:0] mid_level;
  logic                   crossing_hit;
  logic [TS_BITS-1:0]     crossing_time;
  logic [TS_BITS-1:0]     onset_estimate;
  modport source (output valid, output top_level, output bottom_level, output mid_level,
                  output crossing_hit, output crossing_time, output onset_estimate,
                  input ready);
  modport sink   (input valid, input top_level, input bottom_level, input mid_level,
                  input crossing_hit, input crossing_time, input onset_estimate,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/light_edge_midlevel_timestamper_unit.sv @@
`default_nettype none
// Channel   Direction  Carries
// in_ch     sink       sample, timestamp_us
// out_ch    source     levels, crossing flag, crossing time, onset estimate
// cfg_*     write      span_threshold (index 0), onset_offset (index 1)
//
// An ordinary sample passes from idle through the mid-level and hit steps before
// its result register loads. On the last window position with a new top or bottom
// level it also passes the sum, multiply and average steps: one shared adder sums
// the window one entry per cycle, then one multiply by the window length's reciprocal.
// in_ch.ready is high only while the sequencer is idle; a result waiting on
// out_ch holds the sequencer in its last step. Reset is synchronous, active low.
module light_edge_midlevel_timestamper_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  lemt_in_if.sink                                 in_ch,
  lemt_out_if.source                              out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [lemt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [lemt_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import lemt_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SUM  = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_AVG  = 6'b001000,
    ST_MID  = 6'b010000,
    ST_HIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [THR_BITS-1:0]    thr_r;
  logic [TS_BITS-1:0]     off_r;
  logic [SAMPLE_BITS-1:0] s_r, s_nxt;
  logic [TS_BITS-1:0]     ts_r, ts_nxt;
  logic                   upd_top_r, upd_top_nxt;
  logic [POS_BITS-1:0]    idx_r, idx_nxt;
  logic [SUM_BITS-1:0]    acc_r, acc_nxt;
  logic [PROD_BITS-1:0]   prod_r, prod_nxt;
  logic [POS_BITS-1:0]    pos_r, pos_nxt;
  logic [SAMPLE_BITS-1:0] top_r, top_nxt;
  logic [SAMPLE_BITS-1:0] bot_r, bot_nxt;
  logic [SAMPLE_BITS-1:0] mid_r, mid_nxt;
  logic [TS_BITS-1:0]     cross_r, cross_nxt;
  logic [SAMPLE_BITS-1:0] window_r [WINDOW_LEN];

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_hit_r, out_hit_nxt;
  logic [TS_BITS-1:0]     out_onset_r, out_onset_nxt;
  logic [SAMPLE_BITS-1:0] out_top_r, out_top_nxt;
  logic [SAMPLE_BITS-1:0] out_bot_r, out_bot_nxt;
  logic [SAMPLE_BITS-1:0] out_mid_r, out_mid_nxt;

  logic                   win_we;
  logic [SAMPLE_BITS-1:0] win_data;

  logic                   accept;
  logic                   is_new_top, is_new_bot;
  logic [SAMPLE_BITS:0]   span;
  logic [SAMPLE_BITS:0]   diff;
  logic                   hit;
  logic                   out_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && (state_r == ST_IDLE);
  assign is_new_top  = in_ch.sample > top_r;
  assign is_new_bot  = in_ch.sample < bot_r;
  assign span        = {1'b0, top_r} - {1'b0, bot_r};
  assign diff        = {1'b0, s_r} - {1'b0, mid_r};
  assign hit         = (diff == '0) || (diff == (SAMPLE_BITS+1)'(1)) || (diff == '1);
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    s_nxt         = s_r;
    ts_nxt        = ts_r;
    upd_top_nxt   = upd_top_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    pos_nxt       = pos_r;
    top_nxt       = top_r;
    bot_nxt       = bot_r;
    mid_nxt       = mid_r;
    cross_nxt     = cross_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_hit_nxt   = out_hit_r;
    out_onset_nxt = out_onset_r;
    out_top_nxt   = out_top_r;
    out_bot_nxt   = out_bot_r;
    out_mid_nxt   = out_mid_r;
    win_we        = 1'b0;
    win_data      = s_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          s_nxt   = in_ch.sample;
          ts_nxt  = in_ch.timestamp_us;
          idx_nxt = '0;
          acc_nxt = '0;
          if ((pos_r == LAST_POS) && (is_new_top || is_new_bot)) begin
            // The new sample joins the window before the average is taken.
            win_we      = 1'b1;
            win_data    = in_ch.sample;
            upd_top_nxt = is_new_top;
            state_nxt   = ST_SUM;
          end else begin
            state_nxt = ST_MID;
          end
        end
      end
      ST_SUM: begin
        acc_nxt = acc_r + SUM_BITS'(window_r[idx_r]);
        idx_nxt = idx_r + POS_BITS'(1);
        if (idx_r == LAST_POS) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = PROD_BITS'(acc_r) * PROD_BITS'(RECIP);
        state_nxt = ST_AVG;
      end
      ST_AVG: begin
        if (upd_top_r) begin
          top_nxt = prod_r[DIV_SH +: SAMPLE_BITS];
        end else begin
          bot_nxt = prod_r[DIV_SH +: SAMPLE_BITS];
        end
        state_nxt = ST_MID;
      end
      ST_MID: begin
        // A negative span never passes, as its sign bit is set.
        if (!span[SAMPLE_BITS] && (span[SAMPLE_BITS-1:0] > SAMPLE_BITS'(thr_r))) begin
          mid_nxt = top_r - span[SAMPLE_BITS:1];
        end
        state_nxt = ST_HIT;
      end
      ST_HIT: begin
        if (out_free) begin
          win_we        = 1'b1;
          cross_nxt     = hit ? ts_r : cross_r;
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit;
          out_onset_nxt = (hit ? ts_r : cross_r) - off_r;
          // The levels are held here so the next sample may move them while
          // this result still waits.
          out_top_nxt   = top_r;
          out_bot_nxt   = bot_r;
          out_mid_nxt   = mid_r;
          pos_nxt       = (pos_r == LAST_POS) ? '0 : pos_r + POS_BITS'(1);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= THR_RESET;
      off_r       <= OFFSET_RESET;
      pos_r       <= '0;
      top_r       <= '0;
      bot_r       <= '1;
      mid_r       <= '0;
      cross_r     <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < WINDOW_LEN; k++) begin
        window_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      top_r       <= top_nxt;
      bot_r       <= bot_nxt;
      mid_r       <= mid_nxt;
      cross_r     <= cross_nxt;
      out_valid_r <= out_valid_nxt;
      if (win_we) begin
        window_r[pos_r] <= win_data;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SPAN_THRESHOLD: thr_r <= cfg_data[THR_BITS-1:0];
          CFG_ONSET_OFFSET:   off_r <= cfg_data[TS_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    s_r         <= s_nxt;
    ts_r        <= ts_nxt;
    upd_top_r   <= upd_top_nxt;
    idx_r       <= idx_nxt;
    acc_r       <= acc_nxt;
    prod_r      <= prod_nxt;
    out_hit_r   <= out_hit_nxt;
    out_onset_r <= out_onset_nxt;
    out_top_r   <= out_top_nxt;
    out_bot_r   <= out_bot_nxt;
    out_mid_r   <= out_mid_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.top_level      = out_top_r;
  assign out_ch.bottom_level   = out_bot_r;
  assign out_ch.mid_level      = out_mid_r;
  assign out_ch.crossing_hit   = out_hit_r;
  assign out_ch.crossing_time  = cross_r;
  assign out_ch.onset_estimate = out_onset_r;

  // A new result only appears from the final step of the sequencer.
  a_result_from_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_HIT))
    else $error("result appeared outside the final step");

  // Tracked levels only move on the averaging step.
  a_top_stable: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(state_r == ST_AVG)) |-> ($stable(top_r) && $stable(bot_r)))
    else $error("tracked level changed outside the averaging step");

  // The window position moves only when a result is produced.
  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(pos_r)) |-> $rose(out_valid_r) || $past(out_valid_r && out_ch.ready))
    else $error("window position moved without a result");

  // The summing index never runs past the window.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) |-> (idx_r <= LAST_POS))
    else $error("window index out of range");

endmodule
`default_nettype wire
